@@ rtl/core/icmpck_pkg.sv @@
// Shared types, constants and helper functions for the ICMPv6 checksum engine.
package icmpck_pkg;

    // Next header value for ICMPv6 in the pseudo header.
    localparam logic [15:0] NEXT_HEADER_ICMPV6 = 16'd58;

    // Byte position saturates here; every later byte is message data.
    localparam logic [5:0] POS_LIMIT = 6'd48;

    // A packet whose last byte sits below this position is too short.
    localparam logic [5:0] POS_SHORT = 6'd47;

    // One packet byte as it moves from the ingress register to the accumulator.
    typedef struct packed {
        logic       valid;
        logic [7:0] data_byte;
        logic       last_byte;
    } t_item;

    // Ones-complement add with end-around carry.
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            oc_add = s[15:0] + {15'd0, s[16]};
        end
    endfunction

    // True for the byte positions that enter the checksum: the payload length,
    // both addresses and the message apart from its checksum field.
    function automatic logic counts(input logic [5:0] pos);
        begin
            counts = (pos == 6'd4) || (pos == 6'd5) ||
                     ((pos >= 6'd8) && (pos <= 6'd41)) || (pos >= 6'd44);
        end
    endfunction

endpackage

@@ rtl/core/icmpv6_checksum_engine.sv @@
// ICMPv6 checksum engine: one byte per unstalled cycle in, one checksum per packet out.
//
// Feed a whole IPv6 packet one byte per item starting at header byte 0 and mark the
// final byte. The engine sums the pseudo header (addresses, payload length, next
// header 58) and the ICMPv6 message with its checksum field taken as zero, and after
// the marked byte returns one item: the complemented 16-bit sum, whose high byte
// belongs at packet byte 42, plus a flag for packets shorter than 48 bytes (their
// checksum reads zero). It takes one item every cycle while o_in_stall is low, with no
// gaps between packets; the result is offered once the last byte has passed from the
// ingress register through a single end-around-carry adder into the result register.
// A stall on the result side holds the result and, once
// the ingress register is full, stalls the input.
module icmpv6_checksum_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_checksum_value,
    output logic        o_short_packet
);
    import icmpck_pkg::*;

    t_item w_item;
    logic  w_advance;

    // Ingress register.
    icmpck_in_reg u_in_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_advance   (w_advance),
        .o_in_stall  (o_in_stall),
        .o_item      (w_item)
    );

    // Checksum accumulator and result register.
    icmpck_accum u_accum (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_item           (w_item),
        .i_out_stall      (i_out_stall),
        .o_advance        (w_advance),
        .o_out_valid      (o_out_valid),
        .o_checksum_value (o_checksum_value),
        .o_short_packet   (o_short_packet)
    );

endmodule

@@ rtl/core/icmpck_in_reg.sv @@
// Ingress register that captures one packet byte per cycle unless stalled.
module icmpck_in_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic [7:0]         i_data_byte,
    input  logic               i_last_byte,
    input  logic               i_advance,
    output logic               o_in_stall,
    output icmpck_pkg::t_item  o_item
);
    import icmpck_pkg::*;

    logic       r_valid;
    logic [7:0] r_data_byte;
    logic       r_last_byte;
    logic       n_valid;
    logic       w_load;

    // The held item blocks new input only while the downstream side stalls.
    assign o_in_stall = r_valid && !i_advance;
    assign w_load     = !r_valid || i_advance;
    assign n_valid    = i_in_valid;

    // Control bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= n_valid;
        end
    end

    // Payload bits need no reset.
    always_ff @(posedge i_clk) begin
        if (w_load && i_in_valid) begin
            r_data_byte <= i_data_byte;
            r_last_byte <= i_last_byte;
        end
    end

    assign o_item = '{valid: r_valid, data_byte: r_data_byte, last_byte: r_last_byte};

endmodule

@@ rtl/core/icmpck_accum.sv @@
// Running ones-complement sum, byte position tracking and the result register.
module icmpck_accum (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  icmpck_pkg::t_item  i_item,
    input  logic               i_out_stall,
    output logic               o_advance,
    output logic               o_out_valid,
    output logic [15:0]        o_checksum_value,
    output logic               o_short_packet
);
    import icmpck_pkg::*;

    logic [15:0] r_sum;
    logic [5:0]  r_pos;
    logic [7:0]  r_pending;
    logic        r_odd;
    logic        r_out_valid;
    logic [15:0] r_checksum;
    logic        r_short;

    logic [15:0] n_sum;
    logic [5:0]  n_pos;
    logic [7:0]  n_pending;
    logic        n_odd;

    logic        w_fire;
    logic        w_done;
    logic [7:0]  w_byte;
    logic [15:0] w_word;
    logic [15:0] w_sum_add;
    logic        w_short;

    // The whole path moves when the result register is free.
    assign o_advance = !r_out_valid || !i_out_stall;
    assign w_fire    = i_item.valid && o_advance;
    assign w_done    = w_fire && i_item.last_byte;

    // Ignored header bytes contribute zero but still advance the position.
    assign w_byte    = counts(r_pos) ? i_item.data_byte : 8'd0;

    // Complete word: high byte pending on an odd position, else zero-padded.
    assign w_word    = r_odd ? {r_pending, w_byte} : {w_byte, 8'd0};
    assign w_sum_add = oc_add(r_sum, w_word);
    assign w_short   = r_pos < POS_SHORT;

    // Next state. The sum starts at the next header value, which gives the
    // same ones-complement result as adding it at the end.
    always_comb begin
        n_sum     = r_sum;
        n_pos     = r_pos;
        n_pending = r_pending;
        n_odd     = r_odd;
        if (i_item.last_byte) begin
            n_sum     = NEXT_HEADER_ICMPV6;
            n_pos     = 6'd0;
            n_pending = 8'd0;
            n_odd     = 1'b0;
        end else begin
            if (r_odd) begin
                n_sum     = w_sum_add;
                n_pending = 8'd0;
            end else begin
                n_pending = w_byte;
            end
            n_odd = !r_odd;
            if (r_pos < POS_LIMIT) begin
                n_pos = r_pos + 6'd1;
            end
        end
    end

    // Packet state and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= NEXT_HEADER_ICMPV6;
            r_pos       <= 6'd0;
            r_pending   <= 8'd0;
            r_odd       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_sum     <= n_sum;
                r_pos     <= n_pos;
                r_pending <= n_pending;
                r_odd     <= n_odd;
            end
            if (o_advance) begin
                r_out_valid <= w_done;
            end
        end
    end

    // Result payload; a short packet reports a zero checksum.
    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_checksum <= w_short ? 16'd0 : ~w_sum_add;
            r_short    <= w_short;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_checksum_value = r_checksum;
    assign o_short_packet   = r_short;

endmodule

@@ rtl/core/icmpck_checker.sv @@
// Port-level assertions for the ICMPv6 checksum engine and their bind.
module icmpck_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [15:0] o_checksum_value,
    input logic        o_short_packet
);

    // A stalled result item stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result item dropped while stalled");

    // A stalled result item keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_checksum_value) && $stable(o_short_packet))
        else $error("result payload changed while stalled");

    // A short packet always reports a zero checksum.
    a_short_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_short_packet |-> o_checksum_value == 16'd0)
        else $error("short packet with nonzero checksum");

    // The input stalls only when a result is waiting and stalled.
    a_in_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output backpressure");

    // No result is offered right after reset.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind icmpv6_checksum_engine icmpck_checker u_icmpck_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_in_stall       (o_in_stall),
    .o_out_valid      (o_out_valid),
    .i_out_stall      (i_out_stall),
    .o_checksum_value (o_checksum_value),
    .o_short_packet   (o_short_packet)
);

@@ tb/tb.sv @@
// Self-checking testbench for the ICMPv6 checksum engine, with its own byte-level checksum predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import icmpck_pkg::*;

    localparam int WATCHDOG_LIMIT     = 4000;
    localparam int ITEM_TARGET        = 1150;
    localparam int MIN_RANDOM_PACKETS = 40;
    localparam int LONG_HOLD_CYCLES   = 400;
    localparam int PRESSURE_PACKETS   = 40;
    localparam int DRAIN_CYCLES       = 8;

    // Common ICMPv6 message types placed at byte 40 of well-formed packets.
    localparam logic [7:0] ICMP_TYPES [4] = '{8'd1, 8'd128, 8'd129, 8'd135};

    // How the bytes of a generated packet are filled.
    typedef enum int {
        FILL_ZEROS,
        FILL_ONES,
        FILL_WELL_FORMED,
        FILL_NOISE
    } fill_e;

    // One expected checksum item.
    typedef struct packed {
        logic [15:0] checksum;
        logic        short_flag;
    } csum_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic [7:0]  data_byte = 8'h00;
    logic        last_byte = 1'b0;
    logic        out_stall = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic [15:0] checksum_value;
    logic        short_packet;

    // Predictor state: running sum, saturating position, pending high byte, parity.
    logic [15:0] acc_sum;
    logic [5:0]  acc_pos;
    logic [7:0]  acc_hi;
    logic        acc_odd;

    csum_t expected_sums[$];

    int error_count   = 0;
    int items_sent    = 0;
    int packets_sent  = 0;
    int results_seen  = 0;
    int short_seen    = 0;
    int rx_wait       = 0;
    int rx_hold       = 0;
    int quiet_cycles  = 0;
    bit no_idle       = 1'b0;

    always #1 clk = ~clk;

    icmpv6_checksum_engine u_top (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_data_byte      (data_byte),
        .i_last_byte      (last_byte),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_checksum_value (checksum_value),
        .o_short_packet   (short_packet)
    );

    // 16-bit ones-complement add; the carry out wraps back into bit 0.
    function automatic logic [15:0] wrap_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

    // Header bytes outside the pseudo header and the checksum field itself add nothing.
    function automatic bit byte_enters_sum(input logic [5:0] pos);
        case (pos)
            6'd0, 6'd1, 6'd2, 6'd3, 6'd6, 6'd7, 6'd42, 6'd43: return 1'b0;
            default: return 1'b1;
        endcase
    endfunction

    // Wait before the next item, unless a no-idle stretch is running.
    function automatic int draw_wait();
        return no_idle ? 0 : $urandom_range(0, 9);
    endfunction

    // Random byte with extra weight on all-zeros and all-ones.
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hff;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic clear_checksum_state();
        acc_sum = 16'h0000;
        acc_pos = 6'd0;
        acc_hi  = 8'h00;
        acc_odd = 1'b0;
    endtask

    // Advance the predicted checksum by one accepted byte; a last byte yields a result.
    task automatic predict_checksum(input logic [7:0] b, input logic last);
        logic [7:0]  v;
        logic [15:0] s;
        csum_t       r;
        v = byte_enters_sum(acc_pos) ? b : 8'h00;
        if (!acc_odd) begin
            acc_hi = v;
        end else begin
            acc_sum = wrap_add(acc_sum, {acc_hi, v});
            acc_hi  = 8'h00;
        end
        if (!last) begin
            acc_odd = ~acc_odd;
            if (acc_pos < POS_LIMIT) begin
                acc_pos = acc_pos + 6'd1;
            end
        end else begin
            // An odd trailing byte is padded with a zero low byte.
            s = acc_sum;
            if (!acc_odd) begin
                s = wrap_add(s, {acc_hi, 8'h00});
            end
            s = wrap_add(s, NEXT_HEADER_ICMPV6);
            r.short_flag = (acc_pos < POS_SHORT);
            r.checksum   = r.short_flag ? 16'h0000 : ~s;
            expected_sums.push_back(r);
            clear_checksum_state();
        end
    endtask

    task automatic report_mismatch(input string what);
        error_count++;
        $display("MISMATCH at %0t: %s", $time, what);
    endtask

    // Offer one byte after a random gap and hold it until the engine takes it.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= last;
        do @(posedge clk); while (in_stall);
        items_sent++;
        predict_checksum(b, last);
    endtask

    // Build and send one packet of the given length.
    task automatic send_packet(input int len, input fill_e fill);
        logic [7:0]  b;
        logic [15:0] plen;
        plen = (len > 40) ? 16'(len - 40) : 16'h0000;
        for (int i = 0; i < len; i++) begin
            case (fill)
                FILL_ZEROS: b = 8'h00;
                FILL_ONES:  b = 8'hff;
                FILL_NOISE: b = pick_byte();
                default: begin
                    case (i)
                        0:       b = 8'h60;
                        4:       b = plen[15:8];
                        5:       b = plen[7:0];
                        6:       b = NEXT_HEADER_ICMPV6[7:0];
                        7:       b = 8'hff;
                        40:      b = ICMP_TYPES[2'($urandom_range(0, 3))];
                        default: b = pick_byte();
                    endcase
                end
            endcase
            send_byte(b, i == len - 1);
        end
        packets_sent++;
    endtask

    // Header-only packets: single bytes, odd and even lengths, ignored header bytes.
    task automatic test_short_packets();
        send_packet(1, FILL_ZEROS);
        for (int len = 1; len <= 6; len++) begin
            send_packet(len, FILL_ONES);
        end
    endtask

    // The receiver holds off for a long stretch while single-byte packets keep coming.
    task automatic test_backpressure();
        no_idle = 1'b1;
        rx_hold = LONG_HOLD_CYCLES;
        repeat (PRESSURE_PACKETS) send_packet(1, FILL_NOISE);
        no_idle = 1'b0;
    endtask

    // Random packets: mostly well-formed, around the short boundary and past saturation.
    task automatic test_random_packets();
        int    n;
        int    len;
        int    r;
        fill_e fill;
        n = 0;
        while (items_sent < ITEM_TARGET || n < MIN_RANDOM_PACKETS) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                len = $urandom_range(1, 46);
            end else if (r < 65) begin
                len = $urandom_range(46, 49);
            end else if (r < 95) begin
                len = $urandom_range(48, 64);
            end else begin
                len = $urandom_range(65, 160);
            end
            r = $urandom_range(0, 99);
            if (r < 5) begin
                fill = FILL_ZEROS;
            end else if (r < 15) begin
                fill = FILL_ONES;
            end else if (r < 75) begin
                fill = FILL_WELL_FORMED;
            end else begin
                fill = FILL_NOISE;
            end
            no_idle = ($urandom_range(0, 4) == 0);
            send_packet(len, fill);
            n++;
        end
        no_idle = 1'b0;
    endtask

    // Result side: compare each accepted item, then draw the next stall.
    always @(posedge clk) begin : rx_side
        csum_t exp_r;
        if (rst_n && out_valid && !out_stall) begin
            results_seen++;
            if (expected_sums.size() == 0) begin
                report_mismatch("checksum item with no packet pending");
            end else begin
                exp_r = expected_sums.pop_front();
                if (checksum_value !== exp_r.checksum) begin
                    report_mismatch($sformatf("checksum_value got %h expected %h",
                                              checksum_value, exp_r.checksum));
                end
                if (short_packet !== exp_r.short_flag) begin
                    report_mismatch($sformatf("short_packet got %b expected %b",
                                              short_packet, exp_r.short_flag));
                end
                if (exp_r.short_flag) begin
                    short_seen++;
                end
            end
            rx_wait = draw_wait();
        end else if (rx_wait > 0) begin
            rx_wait--;
        end
        if (rx_hold > 0) begin
            rx_hold--;
        end
        out_stall <= (rx_wait > 0) || (rx_hold > 0);
    end

    // Watchdog: too long without any accepted item ends the run.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timed out: %0d cycles with no accepted item", quiet_cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        clear_checksum_state();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        test_short_packets();
        test_backpressure();
        test_random_packets();
        in_valid <= 1'b0;

        // Drain outstanding checksums, then allow the pipeline latency.
        while (expected_sums.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d bytes in %0d packets; checked %0d checksum items, %0d flagged short.",
                 items_sent, packets_sent, results_seen, short_seen);
        $display("Covered header-only and boundary lengths, saturated long packets, %s",
                 "all-ones carries and a long output stall.");
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
